FILE: rtl/core/ptsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority task slot allocator package
// Operation and status codes and the fixed field widths of both channels.
// ----------------------------------------------------------------------------
package ptsa_pkg;

  localparam int unsigned OpW     = 2;
  localparam int unsigned LevelW  = 3;
  localparam int unsigned IdW     = 16;
  localparam int unsigned TickW   = 16;
  localparam int unsigned StatusW = 2;
  localparam int unsigned GroupW  = 7;
  localparam int unsigned SlotW   = 5;

  // Highest priority level that names a group range.
  localparam logic [LevelW-1:0] LEVEL_MAX = 3'd3;

  typedef enum logic [OpW-1:0] {
    OP_TICK   = 2'd0,
    OP_ADD    = 2'd1,
    OP_DELETE = 2'd2,
    OP_FIND   = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_LEVEL = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

endpackage

FILE: rtl/core/ptsa_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority task slot allocator channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ptsa_req_if;
  logic                         valid;
  logic                         ready;
  logic [ptsa_pkg::OpW-1:0]     op;
  logic [ptsa_pkg::LevelW-1:0]  level;
  logic [ptsa_pkg::IdW-1:0]     task_id;
  logic [ptsa_pkg::TickW-1:0]   period;
  logic [ptsa_pkg::TickW-1:0]   start_offset;

  modport source (output valid, op, level, task_id, period, start_offset, input ready);
  modport sink   (input valid, op, level, task_id, period, start_offset, output ready);
endinterface

interface ptsa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ptsa_pkg::StatusW-1:0]  status;
  logic [ptsa_pkg::GroupW-1:0]   group;
  logic [ptsa_pkg::SlotW-1:0]    slot;

  modport source (output valid, status, group, slot, input ready);
  modport sink   (input valid, status, group, slot, output ready);
endinterface

FILE: rtl/core/priority_task_slot_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority task slot allocator
// Bitmap slot table with find-first-zero allocation and id search by level.
// ----------------------------------------------------------------------------
// One request is worked on at a time and gives exactly one response. A tick or
// a request with an invalid level goes straight to its response. An add
// checks one group of its level per cycle and steps past each full group.
// Delete and find read the task id store one slot per cycle through its
// single read port; a hit ends the scan early. A response that is not taken
// holds the block in its last cycle until the response register frees up.
// Delete scans the level's groups upward and stops at the first match; find
// scans them downward, which yields the lowest matching slot of the last
// matching group.
// The occupancy masks are cleared by reset; the id store needs no clearing,
// since an entry is only compared while its used bit is set. Unstarted and
// active marks, period, start tick and the monitor word serve the dispatcher,
// which is not part of this block, and are not kept here.
module priority_task_slot_allocator_top #(
  parameter int unsigned SLOTS_PER_GROUP = 32,
  parameter int unsigned LEVEL0_GROUPS   = 2,
  parameter int unsigned LEVEL1_GROUPS   = 2,
  parameter int unsigned LEVEL2_GROUPS   = 2,
  parameter int unsigned LEVEL3_GROUPS   = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ptsa_req_if.sink   req_i,
  ptsa_rsp_if.source rsp_o
);

  localparam int unsigned TotalGroups = LEVEL0_GROUPS + LEVEL1_GROUPS
                                      + LEVEL2_GROUPS + LEVEL3_GROUPS;
  localparam int unsigned GrpW  = $clog2(TotalGroups);
  localparam int unsigned SlW   = $clog2(SLOTS_PER_GROUP);
  localparam int unsigned AddrW = GrpW + SlW;
  localparam int unsigned Depth = TotalGroups << SlW;

  localparam logic [GrpW-1:0] L3First = GrpW'(0);
  localparam logic [GrpW-1:0] L3Last  = GrpW'(LEVEL3_GROUPS - 1);
  localparam logic [GrpW-1:0] L2First = GrpW'(LEVEL3_GROUPS);
  localparam logic [GrpW-1:0] L2Last  = GrpW'(LEVEL3_GROUPS + LEVEL2_GROUPS - 1);
  localparam logic [GrpW-1:0] L1First = GrpW'(LEVEL3_GROUPS + LEVEL2_GROUPS);
  localparam logic [GrpW-1:0] L1Last  =
    GrpW'(LEVEL3_GROUPS + LEVEL2_GROUPS + LEVEL1_GROUPS - 1);
  localparam logic [GrpW-1:0] L0First =
    GrpW'(LEVEL3_GROUPS + LEVEL2_GROUPS + LEVEL1_GROUPS);
  localparam logic [GrpW-1:0] L0Last  = GrpW'(TotalGroups - 1);
  localparam logic [SlW-1:0]  SlotLast = SlW'(SLOTS_PER_GROUP - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD,
    S_SCAN,
    S_DONE
  } state_e;

  state_e                        state_q;
  ptsa_pkg::op_e                 op_q;
  logic [ptsa_pkg::IdW-1:0]      id_q;
  logic [GrpW-1:0]               grp_q;
  logic [GrpW-1:0]               end_grp_q;
  logic [SlW-1:0]                slot_q;
  logic                          desc_q;
  logic                          iss_act_q;
  logic                          chk_valid_q;
  logic                          chk_used_q;
  logic                          chk_last_q;
  logic [GrpW-1:0]               chk_grp_q;
  logic [SlW-1:0]                chk_slot_q;
  ptsa_pkg::status_e             res_status_q;
  logic [GrpW-1:0]               res_grp_q;
  logic [SlW-1:0]                res_slot_q;
  logic                          out_valid_q;
  ptsa_pkg::status_e             out_status_q;
  logic [GrpW-1:0]               out_grp_q;
  logic [SlW-1:0]                out_slot_q;
  logic [SLOTS_PER_GROUP-1:0]    used_q [TotalGroups];

  logic [ptsa_pkg::IdW-1:0]      task_mem [Depth];
  logic [ptsa_pkg::IdW-1:0]      mem_rd_q;

  logic [GrpW-1:0]               lvl_first;
  logic [GrpW-1:0]               lvl_last;
  logic [SLOTS_PER_GROUP-1:0]    free_bits;
  logic                          ffz_any;
  logic [SlW-1:0]                ffz_pos;
  logic                          cur_used;
  logic                          iss_last;
  logic                          hit;
  logic                          out_free;
  logic                          mem_we;
  logic [AddrW-1:0]              mem_waddr;
  logic [AddrW-1:0]              mem_raddr;

  assign req_i.ready  = (state_q == S_IDLE);
  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.status = out_status_q;
  assign rsp_o.group  = ptsa_pkg::GroupW'(out_grp_q);
  assign rsp_o.slot   = ptsa_pkg::SlotW'(out_slot_q);

  always_comb begin
    unique case (req_i.level[1:0])
      2'd3: begin
        lvl_first = L3First;
        lvl_last  = L3Last;
      end
      2'd2: begin
        lvl_first = L2First;
        lvl_last  = L2Last;
      end
      2'd1: begin
        lvl_first = L1First;
        lvl_last  = L1Last;
      end
      default: begin
        lvl_first = L0First;
        lvl_last  = L0Last;
      end
    endcase
  end

  // Lowest free slot of the group under test.
  always_comb begin
    free_bits = ~used_q[grp_q];
    ffz_any   = |free_bits;
    ffz_pos   = '0;
    for (int i = SLOTS_PER_GROUP - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        ffz_pos = SlW'(i);
      end
    end
  end

  assign cur_used  = used_q[grp_q][slot_q];
  assign iss_last  = (slot_q == SlotLast) && (grp_q == end_grp_q);
  assign hit       = chk_valid_q && chk_used_q && (mem_rd_q == id_q);
  assign out_free  = !out_valid_q || rsp_o.ready;
  assign mem_we    = (state_q == S_ADD) && ffz_any;
  assign mem_waddr = {grp_q, ffz_pos};
  assign mem_raddr = {grp_q, slot_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      task_mem[mem_waddr] <= id_q;
    end
    mem_rd_q <= task_mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= ptsa_pkg::OP_TICK;
      iss_act_q    <= 1'b0;
      chk_valid_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      res_status_q <= ptsa_pkg::ST_OK;
      out_status_q <= ptsa_pkg::ST_OK;
      for (int g = 0; g < TotalGroups; g++) begin
        used_q[g] <= '0;
      end
    end else begin
      if (out_valid_q && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            op_q       <= ptsa_pkg::op_e'(req_i.op);
            id_q       <= req_i.task_id;
            res_grp_q  <= '0;
            res_slot_q <= '0;
            slot_q     <= '0;
            if (ptsa_pkg::op_e'(req_i.op) == ptsa_pkg::OP_TICK) begin
              res_status_q <= ptsa_pkg::ST_OK;
              state_q      <= S_DONE;
            end else if (req_i.level > ptsa_pkg::LEVEL_MAX) begin
              res_status_q <= ptsa_pkg::ST_BAD_LEVEL;
              state_q      <= S_DONE;
            end else if (ptsa_pkg::op_e'(req_i.op) == ptsa_pkg::OP_FIND) begin
              grp_q     <= lvl_last;
              end_grp_q <= lvl_first;
              desc_q    <= 1'b1;
              iss_act_q <= 1'b1;
              state_q   <= S_SCAN;
            end else begin
              grp_q     <= lvl_first;
              end_grp_q <= lvl_last;
              desc_q    <= 1'b0;
              if (ptsa_pkg::op_e'(req_i.op) == ptsa_pkg::OP_ADD) begin
                state_q <= S_ADD;
              end else begin
                iss_act_q <= 1'b1;
                state_q   <= S_SCAN;
              end
            end
          end
        end
        S_ADD: begin
          if (ffz_any) begin
            used_q[grp_q][ffz_pos] <= 1'b1;
            res_status_q <= ptsa_pkg::ST_OK;
            res_grp_q    <= grp_q;
            res_slot_q   <= ffz_pos;
            state_q      <= S_DONE;
          end else if (grp_q == end_grp_q) begin
            res_status_q <= ptsa_pkg::ST_FULL;
            state_q      <= S_DONE;
          end else begin
            grp_q <= grp_q + 1'b1;
          end
        end
        S_SCAN: begin
          // Issue stage reads the id store; the compare stage sees its data in the
          // following cycle together with the used bit taken at issue.
          chk_valid_q <= iss_act_q;
          chk_used_q  <= cur_used;
          chk_last_q  <= iss_last;
          chk_grp_q   <= grp_q;
          chk_slot_q  <= slot_q;
          if (iss_act_q) begin
            if (slot_q == SlotLast) begin
              slot_q <= '0;
              grp_q  <= desc_q ? grp_q - 1'b1 : grp_q + 1'b1;
            end else begin
              slot_q <= slot_q + 1'b1;
            end
            if (iss_last) begin
              iss_act_q <= 1'b0;
            end
          end
          if (hit) begin
            res_status_q <= ptsa_pkg::ST_OK;
            res_grp_q    <= chk_grp_q;
            res_slot_q   <= chk_slot_q;
            iss_act_q    <= 1'b0;
            chk_valid_q  <= 1'b0;
            state_q      <= S_DONE;
          end else if (chk_valid_q && chk_last_q) begin
            res_status_q <= ptsa_pkg::ST_NOT_FOUND;
            chk_valid_q  <= 1'b0;
            state_q      <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_grp_q    <= res_grp_q;
            out_slot_q   <= res_slot_q;
            if (op_q == ptsa_pkg::OP_DELETE && res_status_q == ptsa_pkg::ST_OK) begin
              used_q[res_grp_q][res_slot_q] <= 1'b0;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // The block takes no second request while one is in progress.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request accepted while busy");

  // Only an add can report a full level.
  a_full_from_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE && res_status_q == ptsa_pkg::ST_FULL |-> op_q == ptsa_pkg::OP_ADD)
    else $error("full status from an operation other than add");

  // Only delete and find can miss.
  a_miss_from_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE && res_status_q == ptsa_pkg::ST_NOT_FOUND
      |-> op_q == ptsa_pkg::OP_DELETE || op_q == ptsa_pkg::OP_FIND)
    else $error("not found status from an operation that does not search");

  // The compare stage is only live inside a scan.
  a_chk_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_valid_q |-> state_q == S_SCAN)
    else $error("compare stage active outside a scan");

  // A successful delete frees the slot it reports.
  a_delete_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE && out_free && op_q == ptsa_pkg::OP_DELETE
      && res_status_q == ptsa_pkg::ST_OK
      |=> !used_q[$past(res_grp_q)][$past(res_slot_q)])
    else $error("deleted slot still marked used");

endmodule
